// ===== design/qslerp_pkg.sv =====
// shared types, constants and the arctangent table for the quaternion slerp core
`default_nettype none
package qslerp_pkg;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int COMP_W      = 16;
   localparam int TAR_W       = 17;
   localparam int FACTOR_W    = 17;
   localparam int THRESH_W    = 15;
   localparam int CSR_INDEX_W = 1;
   localparam int C_W         = 30;
   localparam int SQRT_W      = 61;
   localparam int SQRT_BITS   = 31;
   localparam int CXY_W       = 34;
   localparam int CZ_W        = 35;
   localparam int DEN_W       = 32;
   localparam int DIV_W       = 61;
   localparam int QUO_BITS    = 33;
   localparam int COEF_W      = 33;

   localparam logic [CSR_INDEX_W-1:0] REG_BLEND_FACTOR   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LERP_THRESHOLD = 1'd1;
   localparam logic [FACTOR_W-1:0]    FACTOR_ONE         = 17'd65536;
   localparam logic [THRESH_W-1:0]    THRESH_RESET       = 15'd33;

   typedef enum logic [1:0] {
      PATH_COPY   = 2'd0,
      PATH_LINEAR = 2'd1,
      PATH_SPHERE = 2'd2
   } path_type;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [TAR_W-1:0]  tar_type;

   typedef struct packed {
      comp_type [3:0] src;
      tar_type [3:0]  tar;
      path_type       path;
      logic           sph_coef;
      logic           last;
   } side_type;

   // round(atan(2^-i) * 2^30)
   function automatic logic [CZ_W-1:0] atan_entry(input int idx);
      logic [CZ_W-1:0] v;
      case (idx)
         0:  v = 35'd843314857;
         1:  v = 35'd497837829;
         2:  v = 35'd263043837;
         3:  v = 35'd133525159;
         4:  v = 35'd67021687;
         5:  v = 35'd33543516;
         6:  v = 35'd16775851;
         7:  v = 35'd8388437;
         8:  v = 35'd4194283;
         9:  v = 35'd2097149;
         10: v = 35'd1048576;
         11: v = 35'd524288;
         12: v = 35'd262144;
         13: v = 35'd131072;
         14: v = 35'd65536;
         15: v = 35'd32768;
         16: v = 35'd16384;
         17: v = 35'd8192;
         18: v = 35'd4096;
         19: v = 35'd2048;
         20: v = 35'd1024;
         21: v = 35'd512;
         22: v = 35'd256;
         23: v = 35'd128;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== design/qslerp_sqrt_cell.sv =====
// one result bit of the pipelined integer square root
`default_nettype none
module qslerp_sqrt_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             prev_valid,
   input  qslerp_pkg::side_type             prev_side,
   input  logic [qslerp_pkg::C_W-1:0]       prev_c,
   input  logic [qslerp_pkg::SQRT_W-1:0]    prev_rem,
   input  logic [qslerp_pkg::SQRT_W-1:0]    prev_root,
   output logic                             cell_valid,
   output qslerp_pkg::side_type             cell_side,
   output logic [qslerp_pkg::C_W-1:0]       cell_c,
   output logic [qslerp_pkg::SQRT_W-1:0]    cell_rem,
   output logic [qslerp_pkg::SQRT_W-1:0]    cell_root
);
   import qslerp_pkg::*;

   localparam logic [SQRT_W:0] BIT_VAL = {{SQRT_W{1'b0}}, 1'b1} << (2 * BIT_POS);

   logic                valid_ff;
   side_type            side_ff;
   logic [C_W-1:0]      c_ff;
   logic [SQRT_W-1:0]   rem_ff, rem_in;
   logic [SQRT_W-1:0]   root_ff, root_in;
   logic [SQRT_W:0]     trial;

   always_comb begin
      trial = {1'b0, prev_root} + BIT_VAL;
      if ({1'b0, prev_rem} >= trial) begin
         rem_in  = prev_rem - trial[SQRT_W-1:0];
         root_in = (prev_root >> 1) + BIT_VAL[SQRT_W-1:0];
      end else begin
         rem_in  = prev_rem;
         root_in = prev_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= prev_side;
         c_ff    <= prev_c;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_side  = side_ff;
   assign cell_c     = c_ff;
   assign cell_rem   = rem_ff;
   assign cell_root  = root_ff;
endmodule
`default_nettype wire

// ===== design/qslerp_cordic_cell.sv =====
// one micro-rotation of a cordic row, vectoring or rotation, over a few lanes
`default_nettype none
module qslerp_cordic_cell #(
   parameter int STEP      = 0,
   parameter int LANES     = 1,
   parameter bit VECTORING = 1'b0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                prev_valid,
   input  qslerp_pkg::side_type                prev_side,
   input  logic signed [qslerp_pkg::CXY_W-1:0] prev_x [LANES],
   input  logic signed [qslerp_pkg::CXY_W-1:0] prev_y [LANES],
   input  logic signed [qslerp_pkg::CZ_W-1:0]  prev_z [LANES],
   output logic                                cell_valid,
   output qslerp_pkg::side_type                cell_side,
   output logic signed [qslerp_pkg::CXY_W-1:0] cell_x [LANES],
   output logic signed [qslerp_pkg::CXY_W-1:0] cell_y [LANES],
   output logic signed [qslerp_pkg::CZ_W-1:0]  cell_z [LANES]
);
   import qslerp_pkg::*;

   localparam logic signed [CZ_W-1:0] ATAN = $signed(atan_entry(STEP));

   logic                    valid_ff;
   side_type                side_ff;
   logic signed [CXY_W-1:0] x_ff [LANES];
   logic signed [CXY_W-1:0] x_in [LANES];
   logic signed [CXY_W-1:0] y_ff [LANES];
   logic signed [CXY_W-1:0] y_in [LANES];
   logic signed [CZ_W-1:0]  z_ff [LANES];
   logic signed [CZ_W-1:0]  z_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         // vectoring drives y to zero, rotation drives z to zero
         if (VECTORING ? !prev_y[l][CXY_W-1] : prev_z[l][CZ_W-1]) begin
            x_in[l] = prev_x[l] + (prev_y[l] >>> STEP);
            y_in[l] = prev_y[l] - (prev_x[l] >>> STEP);
            z_in[l] = prev_z[l] + ATAN;
         end else begin
            x_in[l] = prev_x[l] - (prev_y[l] >>> STEP);
            y_in[l] = prev_y[l] + (prev_x[l] >>> STEP);
            z_in[l] = prev_z[l] - ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= prev_side;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_side  = side_ff;
   assign cell_x     = x_ff;
   assign cell_y     = y_ff;
   assign cell_z     = z_ff;
endmodule
`default_nettype wire

// ===== design/qslerp_div_cell.sv =====
// one quotient bit of the two-lane restoring divider
`default_nettype none
module qslerp_div_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               prev_valid,
   input  qslerp_pkg::side_type               prev_side,
   input  logic [qslerp_pkg::DEN_W-1:0]       prev_den,
   input  logic [qslerp_pkg::DIV_W-1:0]       prev_rem [2],
   input  logic [qslerp_pkg::QUO_BITS-1:0]    prev_quo [2],
   input  logic [1:0]                         prev_neg,
   input  logic [1:0]                         prev_ovf,
   output logic                               cell_valid,
   output qslerp_pkg::side_type               cell_side,
   output logic [qslerp_pkg::DEN_W-1:0]       cell_den,
   output logic [qslerp_pkg::DIV_W-1:0]       cell_rem [2],
   output logic [qslerp_pkg::QUO_BITS-1:0]    cell_quo [2],
   output logic [1:0]                         cell_neg,
   output logic [1:0]                         cell_ovf
);
   import qslerp_pkg::*;

   localparam int SH_W = DEN_W + QUO_BITS - 1;
   localparam logic [QUO_BITS-1:0] QUO_BIT = {{(QUO_BITS-1){1'b0}}, 1'b1} << BIT_POS;

   logic                valid_ff;
   side_type            side_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [DIV_W-1:0]    rem_ff [2];
   logic [DIV_W-1:0]    rem_in [2];
   logic [QUO_BITS-1:0] quo_ff [2];
   logic [QUO_BITS-1:0] quo_in [2];
   logic [1:0]          neg_ff, ovf_ff;
   logic [SH_W-1:0]     shifted;

   always_comb begin
      shifted = {{(SH_W-DEN_W){1'b0}}, prev_den} << BIT_POS;
      for (int l = 0; l < 2; l++) begin
         if ({{(SH_W-DIV_W){1'b0}}, prev_rem[l]} >= shifted) begin
            rem_in[l] = prev_rem[l] - shifted[DIV_W-1:0];
            quo_in[l] = prev_quo[l] | QUO_BIT;
         end else begin
            rem_in[l] = prev_rem[l];
            quo_in[l] = prev_quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= prev_side;
         den_ff  <= prev_den;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         neg_ff  <= prev_neg;
         ovf_ff  <= prev_ovf;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_side  = side_ff;
   assign cell_den   = den_ff;
   assign cell_rem   = rem_ff;
   assign cell_quo   = quo_ff;
   assign cell_neg   = neg_ff;
   assign cell_ovf   = ovf_ff;
endmodule
`default_nettype wire

// ===== design/quaternion_slerp_core.sv =====
// Quaternion slerp core: a fully pipelined row of cells that takes one source/target
// pair per clock while the result side is not stalled and returns one blended Q1.15
// quaternion per pair, in order. The row holds registers for input capture, products,
// dot product and path select, c squared and radicand, then 31 square-root cells,
// CORDIC_STEPS vectoring cells for the angle, the angle scaling registers,
// CORDIC_STEPS three-lane rotation cells for the sines, a divider setup register and
// 33 divider cells for the coefficients, and registers for coefficient select,
// multiply and round. Every stage moves together; a result held on the response side
// with rsp_ready low freezes the whole row, and req_ready drops in the same cycle.
// Write blend_factor and lerp_threshold only while the core holds no pairs in flight.
`default_nettype none
module quaternion_slerp_core #(
   parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_src_x,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_src_y,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_src_z,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_src_w,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_tar_x,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_tar_y,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_tar_z,
   input  logic signed [qslerp_pkg::COMP_W-1:0] req_tar_w,
   input  logic                                 req_last_pair,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [qslerp_pkg::COMP_W-1:0] rsp_out_x,
   output logic signed [qslerp_pkg::COMP_W-1:0] rsp_out_y,
   output logic signed [qslerp_pkg::COMP_W-1:0] rsp_out_z,
   output logic signed [qslerp_pkg::COMP_W-1:0] rsp_out_w,
   output logic [1:0]                           rsp_blend_path,
   output logic                                 rsp_last_out,
   input  logic                                 csr_wr_en,
   input  logic [qslerp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qslerp_pkg::FACTOR_W-1:0]      csr_wdata
);
   import qslerp_pkg::*;

   localparam int DOT_W  = 34;
   localparam int PROD_W = 2 * COMP_W;
   localparam int ANG_W  = CZ_W + FACTOR_W + 1;
   localparam int PS_W   = COMP_W + COEF_W;
   localparam int PT_W   = TAR_W + COEF_W;
   localparam int ACC_W  = PT_W + 1;

   // configuration
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [FACTOR_W-1:0] f_eff, f_comp;

   always_comb begin
      factor_in = factor_ff;
      thresh_in = thresh_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_BLEND_FACTOR:   factor_in = csr_wdata;
            REG_LERP_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= '0;
         thresh_ff <= THRESH_RESET;
      end else begin
         factor_ff <= factor_in;
         thresh_ff <= thresh_in;
      end
   end

   assign f_eff  = (factor_ff > FACTOR_ONE) ? FACTOR_ONE : factor_ff;
   assign f_comp = FACTOR_ONE - f_eff;

   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // input capture
   logic                    s1_valid_ff;
   logic signed [COMP_W-1:0] s1_src_ff [4];
   logic signed [COMP_W-1:0] s1_tar_ff [4];
   logic                    s1_last_ff;

   // products
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_prod_ff [4];
   logic signed [COMP_W-1:0] s2_src_ff [4];
   logic signed [COMP_W-1:0] s2_tar_ff [4];
   logic                     s2_last_ff;

   // dot, path select, target sign fix
   logic                s3_valid_ff;
   side_type            s3_side_ff, s3_side_in;
   logic [C_W-1:0]      s3_c_ff, s3_c_in;
   logic signed [DOT_W-1:0] dot;
   logic [DOT_W-1:0]    dot_mag, lim;
   logic [COMP_W-1:0]   span;
   logic                is_copy, is_sph;

   // c squared and radicand
   logic                s4_valid_ff;
   side_type            s4_side_ff;
   logic [C_W-1:0]      s4_c_ff;
   logic [2*C_W-1:0]    s4_csq_ff;
   logic                s5_valid_ff;
   side_type            s5_side_ff;
   logic [C_W-1:0]      s5_c_ff;
   logic [SQRT_W-1:0]   s5_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_comb begin
      dot = '0;
      for (int k = 0; k < 4; k++) begin
         dot = dot + DOT_W'(s2_prod_ff[k]);
      end
      dot_mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
      span    = 16'd32768 - {1'b0, thresh_ff};
      lim     = {3'b000, span, 15'd0};
      is_copy = (dot >= 34'sd1073741824);
      is_sph  = !is_copy && (dot_mag < lim);
      s3_side_in.path     = is_copy ? PATH_COPY : (is_sph ? PATH_SPHERE : PATH_LINEAR);
      s3_side_in.sph_coef = 1'b0;
      s3_side_in.last     = s2_last_ff;
      for (int k = 0; k < 4; k++) begin
         s3_side_in.src[k] = s2_src_ff[k];
         s3_side_in.tar[k] = dot[DOT_W-1] ? -TAR_W'(s2_tar_ff[k]) : TAR_W'(s2_tar_ff[k]);
      end
      s3_c_in = is_sph ? dot_mag[C_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_src_ff[0] <= req_src_x;
         s1_src_ff[1] <= req_src_y;
         s1_src_ff[2] <= req_src_z;
         s1_src_ff[3] <= req_src_w;
         s1_tar_ff[0] <= req_tar_x;
         s1_tar_ff[1] <= req_tar_y;
         s1_tar_ff[2] <= req_tar_z;
         s1_tar_ff[3] <= req_tar_w;
         s1_last_ff   <= req_last_pair;
         for (int k = 0; k < 4; k++) begin
            s2_prod_ff[k] <= s1_src_ff[k] * s1_tar_ff[k];
         end
         s2_src_ff  <= s1_src_ff;
         s2_tar_ff  <= s1_tar_ff;
         s2_last_ff <= s1_last_ff;
         s3_side_ff <= s3_side_in;
         s3_c_ff    <= s3_c_in;
         s4_side_ff <= s3_side_ff;
         s4_c_ff    <= s3_c_ff;
         s4_csq_ff  <= s3_c_ff * s3_c_ff;
         s5_side_ff <= s4_side_ff;
         s5_c_ff    <= s4_c_ff;
         s5_rad_ff  <= ({{(SQRT_W-1){1'b0}}, 1'b1} << (2 * C_W)) - SQRT_W'(s4_csq_ff);
      end
   end

   // square root row
   logic              sq_valid [SQRT_BITS+1];
   side_type          sq_side  [SQRT_BITS+1];
   logic [C_W-1:0]    sq_c     [SQRT_BITS+1];
   logic [SQRT_W-1:0] sq_rem   [SQRT_BITS+1];
   logic [SQRT_W-1:0] sq_root  [SQRT_BITS+1];

   assign sq_valid[0] = s5_valid_ff;
   assign sq_side[0]  = s5_side_ff;
   assign sq_c[0]     = s5_c_ff;
   assign sq_rem[0]   = s5_rad_ff;
   assign sq_root[0]  = '0;

   for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
      qslerp_sqrt_cell #(.BIT_POS(SQRT_BITS - 1 - g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_valid (sq_valid[g]),
         .prev_side  (sq_side[g]),
         .prev_c     (sq_c[g]),
         .prev_rem   (sq_rem[g]),
         .prev_root  (sq_root[g]),
         .cell_valid (sq_valid[g+1]),
         .cell_side  (sq_side[g+1]),
         .cell_c     (sq_c[g+1]),
         .cell_rem   (sq_rem[g+1]),
         .cell_root  (sq_root[g+1])
      );
   end

   // vectoring row: angle between source and target
   logic                    vc_valid [CORDIC_STEPS+1];
   side_type                vc_side  [CORDIC_STEPS+1];
   logic signed [CXY_W-1:0] vc_x     [CORDIC_STEPS+1][1];
   logic signed [CXY_W-1:0] vc_y     [CORDIC_STEPS+1][1];
   logic signed [CZ_W-1:0]  vc_z     [CORDIC_STEPS+1][1];

   assign vc_valid[0] = sq_valid[SQRT_BITS];
   assign vc_side[0]  = sq_side[SQRT_BITS];
   assign vc_x[0][0]  = $signed(CXY_W'(sq_c[SQRT_BITS]));
   assign vc_y[0][0]  = $signed(sq_root[SQRT_BITS][CXY_W-1:0]);
   assign vc_z[0][0]  = '0;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
      qslerp_cordic_cell #(.STEP(g), .LANES(1), .VECTORING(1'b1)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_valid (vc_valid[g]),
         .prev_side  (vc_side[g]),
         .prev_x     (vc_x[g]),
         .prev_y     (vc_y[g]),
         .prev_z     (vc_z[g]),
         .cell_valid (vc_valid[g+1]),
         .cell_side  (vc_side[g+1]),
         .cell_x     (vc_x[g+1]),
         .cell_y     (vc_y[g+1]),
         .cell_z     (vc_z[g+1])
      );
   end

   // split the angle by the blend factor
   logic                    m1_valid_ff, m2_valid_ff;
   side_type                m1_side_ff, m2_side_ff;
   logic signed [CZ_W-1:0]  m1_om_ff, m2_om_ff;
   logic signed [ANG_W-1:0] m1_pa_ff, m1_pt_ff;
   logic signed [CZ_W-1:0]  m2_as_ff, m2_at_ff;
   logic signed [ANG_W-1:0] round_a, round_t;

   assign round_a = (m1_pa_ff + ANG_W'(32768)) >>> 16;
   assign round_t = (m1_pt_ff + ANG_W'(32768)) >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= vc_valid[CORDIC_STEPS];
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_side_ff <= vc_side[CORDIC_STEPS];
         m1_om_ff   <= vc_z[CORDIC_STEPS][0];
         m1_pa_ff   <= $signed({1'b0, f_comp}) * vc_z[CORDIC_STEPS][0];
         m1_pt_ff   <= $signed({1'b0, f_eff}) * vc_z[CORDIC_STEPS][0];
         m2_side_ff <= m1_side_ff;
         m2_om_ff   <= m1_om_ff;
         m2_as_ff   <= round_a[CZ_W-1:0];
         m2_at_ff   <= round_t[CZ_W-1:0];
      end
   end

   // rotation row: lanes are source angle, target angle, full angle
   logic                    rc_valid [CORDIC_STEPS+1];
   side_type                rc_side  [CORDIC_STEPS+1];
   logic signed [CXY_W-1:0] rc_x     [CORDIC_STEPS+1][3];
   logic signed [CXY_W-1:0] rc_y     [CORDIC_STEPS+1][3];
   logic signed [CZ_W-1:0]  rc_z     [CORDIC_STEPS+1][3];

   assign rc_valid[0] = m2_valid_ff;
   assign rc_side[0]  = m2_side_ff;
   assign rc_z[0][0]  = m2_as_ff;
   assign rc_z[0][1]  = m2_at_ff;
   assign rc_z[0][2]  = m2_om_ff;
   for (genvar l = 0; l < 3; l++) begin : g_rot_seed
      assign rc_x[0][l] = CXY_W'(1) <<< 30;
      assign rc_y[0][l] = '0;
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
      qslerp_cordic_cell #(.STEP(g), .LANES(3), .VECTORING(1'b0)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_valid (rc_valid[g]),
         .prev_side  (rc_side[g]),
         .prev_x     (rc_x[g]),
         .prev_y     (rc_y[g]),
         .prev_z     (rc_z[g]),
         .cell_valid (rc_valid[g+1]),
         .cell_side  (rc_side[g+1]),
         .cell_x     (rc_x[g+1]),
         .cell_y     (rc_y[g+1]),
         .cell_z     (rc_z[g+1])
      );
   end

   // divider setup: magnitudes, signs and quotient overflow
   logic                    d0_valid_ff;
   side_type                d0_side_ff, d0_side_in;
   logic [DEN_W-1:0]        d0_den_ff, d0_den_in;
   logic [DIV_W-1:0]        d0_num_ff [2];
   logic [DIV_W-1:0]        d0_num_in [2];
   logic [1:0]              d0_neg_ff, d0_neg_in, d0_ovf_ff, d0_ovf_in;
   logic signed [CXY_W-1:0] den_s, num_s;
   logic [CXY_W-1:0]        num_mag;
   logic                    den_pos;

   always_comb begin
      den_s      = rc_y[CORDIC_STEPS][2];
      den_pos    = !den_s[CXY_W-1] && (den_s != '0);
      d0_den_in  = den_pos ? den_s[DEN_W-1:0] : DEN_W'(1);
      d0_side_in = rc_side[CORDIC_STEPS];
      d0_side_in.sph_coef = (rc_side[CORDIC_STEPS].path == PATH_SPHERE) && den_pos;
      num_s   = '0;
      num_mag = '0;
      for (int l = 0; l < 2; l++) begin
         num_s        = rc_y[CORDIC_STEPS][l];
         num_mag      = num_s[CXY_W-1] ? CXY_W'(-num_s) : CXY_W'(num_s);
         d0_neg_in[l] = num_s[CXY_W-1];
         d0_num_in[l] = {num_mag[DIV_W-31:0], 30'd0};
         // quotient would need more than the row's bits: saturates anyway
         d0_ovf_in[l] = {4'd0, d0_num_in[l]} >= {d0_den_in, {QUO_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else if (adv) begin
         d0_valid_ff <= rc_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d0_side_ff <= d0_side_in;
         d0_den_ff  <= d0_den_in;
         d0_num_ff  <= d0_num_in;
         d0_neg_ff  <= d0_neg_in;
         d0_ovf_ff  <= d0_ovf_in;
      end
   end

   // divider row
   logic                dv_valid [QUO_BITS+1];
   side_type            dv_side  [QUO_BITS+1];
   logic [DEN_W-1:0]    dv_den   [QUO_BITS+1];
   logic [DIV_W-1:0]    dv_rem   [QUO_BITS+1][2];
   logic [QUO_BITS-1:0] dv_quo   [QUO_BITS+1][2];
   logic [1:0]          dv_neg   [QUO_BITS+1];
   logic [1:0]          dv_ovf   [QUO_BITS+1];

   assign dv_valid[0]  = d0_valid_ff;
   assign dv_side[0]   = d0_side_ff;
   assign dv_den[0]    = d0_den_ff;
   assign dv_rem[0]    = d0_num_ff;
   assign dv_quo[0][0] = '0;
   assign dv_quo[0][1] = '0;
   assign dv_neg[0]    = d0_neg_ff;
   assign dv_ovf[0]    = d0_ovf_ff;

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
      qslerp_div_cell #(.BIT_POS(QUO_BITS - 1 - g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_valid (dv_valid[g]),
         .prev_side  (dv_side[g]),
         .prev_den   (dv_den[g]),
         .prev_rem   (dv_rem[g]),
         .prev_quo   (dv_quo[g]),
         .prev_neg   (dv_neg[g]),
         .prev_ovf   (dv_ovf[g]),
         .cell_valid (dv_valid[g+1]),
         .cell_side  (dv_side[g+1]),
         .cell_den   (dv_den[g+1]),
         .cell_rem   (dv_rem[g+1]),
         .cell_quo   (dv_quo[g+1]),
         .cell_neg   (dv_neg[g+1]),
         .cell_ovf   (dv_ovf[g+1])
      );
   end

   // coefficient select, blend multiply, round and saturate
   localparam logic [QUO_BITS-1:0] COEF_LIM = {{(QUO_BITS-1){1'b0}}, 1'b1} << 31;

   logic                     f0_valid_ff, f1_valid_ff;
   side_type                 f0_side_ff, f1_side_ff;
   logic signed [COEF_W-1:0] f0_coef_ff [2];
   logic signed [COEF_W-1:0] f0_coef_in [2];
   logic signed [PS_W-1:0]   f1_ps_ff [4];
   logic signed [PT_W-1:0]   f1_pt_ff [4];
   logic signed [COMP_W-1:0] out_ff [4];
   logic signed [COMP_W-1:0] out_in [4];
   path_type                 path_ff;
   logic                     last_ff;
   logic [QUO_BITS-1:0]      quo_mag;
   logic signed [ACC_W-1:0]  acc;

   always_comb begin
      quo_mag = '0;
      for (int l = 0; l < 2; l++) begin
         quo_mag = (dv_ovf[QUO_BITS][l] || (dv_quo[QUO_BITS][l] > COEF_LIM))
                   ? COEF_LIM : dv_quo[QUO_BITS][l];
         if (dv_side[QUO_BITS].sph_coef) begin
            f0_coef_in[l] = dv_neg[QUO_BITS][l] ? -$signed(quo_mag) : $signed(quo_mag);
         end else if (l == 0) begin
            f0_coef_in[l] = $signed(COEF_W'({f_comp, 14'd0}));
         end else begin
            f0_coef_in[l] = $signed(COEF_W'({f_eff, 14'd0}));
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         acc = (ACC_W'(f1_ps_ff[k]) + ACC_W'(f1_pt_ff[k]) + ACC_W'(1 << 29)) >>> 30;
         if (f1_side_ff.path == PATH_COPY) begin
            out_in[k] = f1_side_ff.src[k];
         end else if (acc > ACC_W'(32767)) begin
            out_in[k] = 16'sh7fff;
         end else if (acc < -ACC_W'(32768)) begin
            out_in[k] = -16'sh8000;
         end else begin
            out_in[k] = acc[COMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff  <= 1'b0;
         f1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         f0_valid_ff  <= dv_valid[QUO_BITS];
         f1_valid_ff  <= f0_valid_ff;
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f0_side_ff <= dv_side[QUO_BITS];
         f0_coef_ff <= f0_coef_in;
         f1_side_ff <= f0_side_ff;
         for (int k = 0; k < 4; k++) begin
            f1_ps_ff[k] <= $signed(f0_side_ff.src[k]) * f0_coef_ff[0];
            f1_pt_ff[k] <= $signed(f0_side_ff.tar[k]) * f0_coef_ff[1];
         end
         out_ff  <= out_in;
         path_ff <= f1_side_ff.path;
         last_ff <= f1_side_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_ff[0];
   assign rsp_out_y      = out_ff[1];
   assign rsp_out_z      = out_ff[2];
   assign rsp_out_w      = out_ff[3];
   assign rsp_blend_path = path_ff;
   assign rsp_last_out   = last_ff;
endmodule
`default_nettype wire

// ===== design/qslerp_checker.sv =====
// port-level checks for the quaternion slerp core and their bind
`default_nettype none
module qslerp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_out_w,
   input logic [1:0]  rsp_blend_path
);
   // a held result must stall intake
   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("intake open while result stalled");

   // an empty output always takes a new beat
   a_empty_takes_beat: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("intake closed with empty output");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stalled_beat_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_w) && $stable(rsp_blend_path))
      else $error("stalled result changed");
endmodule

bind quaternion_slerp_core qslerp_checker u_qslerp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_w      (rsp_out_w),
   .rsp_blend_path (rsp_blend_path)
);
`default_nettype wire

// ===== dv/quaternion_slerp_checker.sv =====
// scoreboard for the quaternion slerp core: predicts each blend and compares the result beats
`timescale 1ns / 100ps
module quaternion_slerp_checker
   import qslerp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [15:0]      req_src_x,
   input  logic signed [15:0]      req_src_y,
   input  logic signed [15:0]      req_src_z,
   input  logic signed [15:0]      req_src_w,
   input  logic signed [15:0]      req_tar_x,
   input  logic signed [15:0]      req_tar_y,
   input  logic signed [15:0]      req_tar_z,
   input  logic signed [15:0]      req_tar_w,
   input  logic                    req_last_pair,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [15:0]      rsp_out_x,
   input  logic signed [15:0]      rsp_out_y,
   input  logic signed [15:0]      rsp_out_z,
   input  logic signed [15:0]      rsp_out_w,
   input  logic [1:0]              rsp_blend_path,
   input  logic                    rsp_last_out,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [FACTOR_W-1:0]     csr_wdata,
   output int                      fail_count,
   output int                      pending,
   output int                      path_seen [3]
);
   localparam int STEPS = CORDIC_STEPS_DEFAULT;

   typedef struct {
      logic signed [15:0] q [4];
      path_type           path;
      logic               last;
   } blend_type;

   logic [FACTOR_W-1:0] factor_reg;
   logic [THRESH_W-1:0] thresh_reg;
   blend_type           expected_blends [$];

   function automatic longint atan_val(input int i);
      return longint'(atan_entry(i));
   endfunction

   function automatic longint isqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(input longint x, input longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_val(i);
         end else begin
            x -= dx; y += dy; z -= atan_val(i);
         end
      end
      return z;
   endfunction

   function automatic longint rotate_sine(input longint z);
      longint x, y, dx, dy;
      x = 64'sd1 << 30;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_val(i);
         end else begin
            x += dx; y -= dy; z += atan_val(i);
         end
      end
      return y;
   endfunction

   function automatic longint coef_ratio(input longint num, input longint den);
      longint q;
      q = (num * (64'sd1 << 30)) / den;
      if (q > (64'sd1 << 31)) q = 64'sd1 << 31;
      if (q < -(64'sd1 << 31)) q = -(64'sd1 << 31);
      return q;
   endfunction

   function automatic blend_type slerp_predict(input longint s [4], input longint t [4],
                                               input logic last);
      blend_type r;
      longint d, c, cs, ct, f, sn, om, as, at, den, v;
      d = 0;
      for (int k = 0; k < 4; k++) d += s[k] * t[k];
      r.last = last;
      if (d >= (64'sd1 << 30)) begin
         for (int k = 0; k < 4; k++) r.q[k] = s[k][15:0];
         r.path = PATH_COPY;
         return r;
      end
      c = d;
      if (d < 0) begin
         c = -d;
         for (int k = 0; k < 4; k++) t[k] = -t[k];
      end
      f = (factor_reg > FACTOR_ONE) ? 65536 : longint'(factor_reg);
      cs = (65536 - f) << 14;
      ct = f << 14;
      r.path = PATH_LINEAR;
      if (c < (longint'(32768 - longint'(thresh_reg)) << 15)) begin
         sn = isqrt((64'd1 << 60) - longint'(c) * longint'(c));
         om = vector_angle(c, sn);
         as = ((65536 - f) * om + 32768) >>> 16;
         at = (f * om + 32768) >>> 16;
         den = rotate_sine(om);
         r.path = PATH_SPHERE;
         // degenerate sine keeps the linear coefficients
         if (den > 0) begin
            cs = coef_ratio(rotate_sine(as), den);
            ct = coef_ratio(rotate_sine(at), den);
         end
      end
      for (int k = 0; k < 4; k++) begin
         v = (s[k] * cs + t[k] * ct + (64'sd1 << 29)) >>> 30;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         r.q[k] = v[15:0];
      end
      return r;
   endfunction

   assign pending = expected_blends.size();

   initial begin
      fail_count = 0;
      for (int i = 0; i < 3; i++) path_seen[i] = 0;
   end

   always @(posedge clock) begin
      longint s [4];
      longint t [4];
      blend_type e;
      logic signed [15:0] got [4];
      if (reset) begin
         factor_reg <= '0;
         thresh_reg <= THRESH_RESET;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_BLEND_FACTOR) factor_reg <= csr_wdata;
            else if (csr_index == REG_LERP_THRESHOLD) thresh_reg <= csr_wdata[THRESH_W-1:0];
         end
         if (req_valid && req_ready) begin
            s = '{req_src_x, req_src_y, req_src_z, req_src_w};
            t = '{req_tar_x, req_tar_y, req_tar_z, req_tar_w};
            e = slerp_predict(s, t, req_last_pair);
            path_seen[e.path]++;
            expected_blends.push_back(e);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w};
            if (expected_blends.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: %0d %0d %0d %0d path %0d",
                           got[0], got[1], got[2], got[3], rsp_blend_path);
            end else begin
               e = expected_blends.pop_front();
               if (got != e.q || rsp_blend_path != e.path || rsp_last_out != e.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp %0d %0d %0d %0d p%0d l%0d got %0d %0d %0d %0d p%0d l%0d",
                              e.q[0], e.q[1], e.q[2], e.q[3], e.path, e.last,
                              got[0], got[1], got[2], got[3], rsp_blend_path, rsp_last_out);
               end
            end
         end
      end
   end
endmodule

// ===== dv/quaternion_slerp_core_tb.sv =====
// top of the quaternion slerp core bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module quaternion_slerp_core_tb;
   import qslerp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_src_x = 0, req_src_y = 0, req_src_z = 0, req_src_w = 0;
   logic signed [15:0] req_tar_x = 0, req_tar_y = 0, req_tar_z = 0, req_tar_w = 0;
   logic req_last_pair = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic [1:0] rsp_blend_path;
   logic rsp_last_out;
   logic csr_wr_en = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [FACTOR_W-1:0] csr_wdata = '0;

   int fail_count, pending;
   int path_seen [3];
   int send_idle = 0, recv_stall = 0;
   int cycles = 0, sent = 0;

   quaternion_slerp_core dut (.*);
   quaternion_slerp_checker scoreboard (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("quaternion_slerp_core verification failed");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall);

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val[FACTOR_W-1:0];
      @(posedge clock);
   endtask

   task automatic send_pair(input int q [8], input logic last);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      {req_src_x, req_src_y, req_src_z, req_src_w} <= {q[0][15:0], q[1][15:0], q[2][15:0], q[3][15:0]};
      {req_tar_x, req_tar_y, req_tar_z, req_tar_w} <= {q[4][15:0], q[5][15:0], q[6][15:0], q[7][15:0]};
      req_last_pair <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random pair: mostly unit-scale quaternions near or opposite each other
   task automatic random_pair(output int q [8]);
      int mode, d;
      mode = $urandom_range(9);
      d = (mode < 6) ? (1 << $urandom_range(12)) : 0;
      for (int k = 0; k < 4; k++) begin
         if (mode >= 8) begin
            q[k] = $urandom_range(65535) - 32768;
            q[k+4] = $urandom_range(65535) - 32768;
         end else begin
            q[k] = $urandom_range(32767) - 16384;
            if (mode >= 6) q[k+4] = $urandom_range(32767) - 16384;
            else if (mode >= 3) q[k+4] = -q[k] + $urandom_range(d) - d / 2;
            else q[k+4] = q[k] + $urandom_range(d) - d / 2;
         end
      end
   endtask

   initial begin
      int q [8];
      int factors [6] = '{0, 65536, 32768, 100000, 131071, 0};
      int threshs [6] = '{33, 33, 0, 32767, 16000, 0};
      int idles [6] = '{0, 62, 0, 29, 0, 62};
      int stalls [6] = '{0, 0, 62, 29, 62, 0};
      int directed [12][8] = '{
         '{0, 0, 0, 0, 0, 0, 0, 0},
         '{-32768, 0, 0, 0, -32768, 0, 0, 0},
         '{16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384},
         '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
         '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
         '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767},
         '{32767, 0, 0, 0, 0, 32767, 0, 0},
         '{32767, 0, 0, 0, 23170, 23170, 0, 0},
         '{32767, 0, 0, 0, -23170, 23170, 0, 0},
         '{32767, 0, 0, 0, 32766, 1, 0, 0},
         '{16384, -16384, 16384, -16384, -16380, 16390, -16384, 16384},
         '{-1, 1, -32768, 32767, 1, -1, 32767, -32768}};
      repeat (8) @(posedge clock);
      reset <= 0;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) begin
            factors[ph] = $urandom_range(65536);
            threshs[ph] = $urandom_range(2000);
         end
         write_reg(REG_BLEND_FACTOR, factors[ph]);
         write_reg(REG_LERP_THRESHOLD, threshs[ph]);
         csr_wr_en <= 0;
         send_idle = idles[ph];
         recv_stall = stalls[ph];
         if (ph < 3)
            foreach (directed[i]) send_pair(directed[i], i[0]);
         for (int i = 0; i < 125; i++) begin
            random_pair(q);
            send_pair(q, $urandom_range(1));
         end
         drain();
      end
      recv_stall = 0;
      repeat (120) @(posedge clock);
      $display("sent %0d pairs over six register settings and idle patterns", sent);
      $display("paths: %0d copied, %0d linear, %0d spherical",
               path_seen[0], path_seen[1], path_seen[2]);
      if (fail_count == 0 && pending == 0) begin
         $display("quaternion_slerp_core verification clean");
      end else begin
         $display("quaternion_slerp_core verification failed");
      end
      $finish;
   end
endmodule
